// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker of the trie unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, held off while rst_n is low.
`define MXST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mxst assertion failed");

// Concurrent assertion on clk that also holds through reset.
`define MXST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mxst assertion failed during or after reset");

`endif

// ===== design/mxst_pkg.sv =====
// Shared constants of the maximum XOR subarray trie unit.
// No dependencies.
`timescale 1ns / 1ps

package mxst_pkg;

  // Fixed width of the value and best_xor fields on the ports.
  parameter int unsigned FIELD_W = 31;

endpackage

// ===== design/mxst_node_ram.sv =====
// Node memory of the trie: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mxst_node_ram #(
  parameter int unsigned ADDR_BITS = 15,
  parameter int unsigned DATA_BITS = 30
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mxst_ctrl.sv =====
// Sequencer of the trie unit: restart seeding, query walk, insert walk.
// Depends on mxst_pkg; drives the ports of mxst_node_ram.
`timescale 1ns / 1ps

module mxst_ctrl
  import mxst_pkg::*;
#(
  parameter int unsigned VALUE_BITS     = 31,
  parameter int unsigned MAX_ITEMS      = 1023,
  parameter int unsigned NODE_ADDR_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FIELD_W-1:0]            in_value,
  input  logic                          in_first,
  output logic                          mem_wr_en,
  output logic [NODE_ADDR_BITS-1:0]     mem_wr_addr,
  output logic [2*NODE_ADDR_BITS-1:0]   mem_wr_data,
  output logic                          mem_rd_en,
  output logic [NODE_ADDR_BITS-1:0]     mem_rd_addr,
  input  logic [2*NODE_ADDR_BITS-1:0]   mem_rd_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [FIELD_W-1:0]            res_best,
  output logic                          res_full
);

  localparam int unsigned AW       = NODE_ADDR_BITS;
  localparam int unsigned DW       = 2 * AW;
  localparam int unsigned NW       = AW + 1;
  localparam int unsigned FW       = AW + 2;
  localparam int unsigned BW       = $clog2(VALUE_BITS);
  localparam int unsigned CW       = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EW       = FIELD_W + 1;
  localparam int unsigned NODE_CAP = 1 << AW;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_RESTART = 7'b0000010,
    ST_CHAIN   = 7'b0000100,
    ST_CHECK   = 7'b0001000,
    ST_QUERY   = 7'b0010000,
    ST_INSERT  = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  pend_r, pend_nxt;
  logic                  seeding_r, seeding_nxt;
  logic [FIELD_W-1:0]    value_r, value_nxt;
  logic [NW-1:0]         node_count_r, node_count_nxt;
  logic [VALUE_BITS-1:0] prefix_r, prefix_nxt;
  logic [VALUE_BITS-1:0] best_r, best_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [CW-1:0]         item_count_r, item_count_nxt;
  logic [BW-1:0]         bit_idx_r, bit_idx_nxt;
  logic [AW-1:0]         node_r, node_nxt;
  logic                  full_r, full_nxt;

  logic [EW-1:0]         value_ext;
  logic [EW-1:0]         best_ext;
  logic [VALUE_BITS-1:0] value_used;
  logic                  cur_bit;
  logic                  link_bit;
  logic [AW-1:0]         child0, child1, other_c, same_c;
  logic [AW-1:0]         link;
  logic [NW-1:0]         count_inc;
  logic [VALUE_BITS-1:0] acc_step;
  logic                  is_full;

  assign value_ext  = EW'(value_r);
  assign value_used = value_ext[VALUE_BITS-1:0];
  assign best_ext   = EW'(best_r);
  assign res_best   = best_ext[FIELD_W-1:0];
  assign res_full   = full_r;
  assign res_valid  = (state_r == ST_DONE);
  assign in_ready   = (state_r == ST_IDLE);

  assign cur_bit   = prefix_r[bit_idx_r];
  assign link_bit  = (bit_idx_r == '0) ? 1'b0 : prefix_r[bit_idx_r - 1'b1];
  assign child0    = mem_rd_data[AW-1:0];
  assign child1    = mem_rd_data[DW-1:AW];
  assign other_c   = cur_bit ? child0 : child1;
  assign same_c    = cur_bit ? child1 : child0;
  assign count_inc = node_count_r + 1'b1;
  assign acc_step  = acc_r | (VALUE_BITS'(1) << bit_idx_r);

  // The chain node links to the next one unless it is the leaf or memory is full.
  assign link = ((bit_idx_r != '0) && (count_inc != NW'(NODE_CAP))) ?
                count_inc[AW-1:0] : '0;

  // Refuse the item when the item limit is reached or room for a full path is not guaranteed.
  assign is_full = (item_count_r >= CW'(MAX_ITEMS)) ||
                   (({1'b0, node_count_r} + FW'(VALUE_BITS)) > FW'(NODE_CAP));

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    seeding_nxt    = seeding_r;
    value_nxt      = value_r;
    node_count_nxt = node_count_r;
    prefix_nxt     = prefix_r;
    best_nxt       = best_r;
    acc_nxt        = acc_r;
    item_count_nxt = item_count_r;
    bit_idx_nxt    = bit_idx_r;
    node_nxt       = node_r;
    full_nxt       = full_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = '0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          value_nxt = in_value;
          pend_nxt  = 1'b1;
          state_nxt = in_first ? ST_RESTART : ST_CHECK;
        end
      end
      ST_RESTART: begin
        // Root gets a single child on the zero side: the start of the seed chain.
        mem_wr_en      = 1'b1;
        mem_wr_addr    = '0;
        mem_wr_data    = DW'(1);
        node_count_nxt = NW'(1);
        prefix_nxt     = '0;
        best_nxt       = '0;
        item_count_nxt = '0;
        bit_idx_nxt    = BW'(VALUE_BITS - 1);
        seeding_nxt    = 1'b1;
        state_nxt      = ST_CHAIN;
      end
      ST_CHAIN: begin
        if (node_count_r == NW'(NODE_CAP)) begin
          state_nxt = seeding_r ? (pend_r ? ST_CHECK : ST_IDLE) : ST_DONE;
        end else begin
          // Fresh node: only the child along the next prefix bit is set.
          mem_wr_en      = 1'b1;
          mem_wr_addr    = node_count_r[AW-1:0];
          mem_wr_data    = link_bit ? {link, AW'(0)} : {AW'(0), link};
          node_count_nxt = count_inc;
          if (bit_idx_r == '0) begin
            state_nxt = seeding_r ? (pend_r ? ST_CHECK : ST_IDLE) : ST_DONE;
          end else begin
            bit_idx_nxt = bit_idx_r - 1'b1;
          end
        end
      end
      ST_CHECK: begin
        full_nxt = is_full;
        if (is_full) begin
          state_nxt = ST_DONE;
        end else begin
          prefix_nxt     = prefix_r ^ value_used;
          item_count_nxt = item_count_r + 1'b1;
          mem_rd_en      = 1'b1;
          mem_rd_addr    = '0;
          node_nxt       = '0;
          acc_nxt        = '0;
          bit_idx_nxt    = BW'(VALUE_BITS - 1);
          state_nxt      = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if ((other_c == '0 && same_c == '0) || bit_idx_r == '0) begin
          // A dead end leaves the maximum as it was.
          if (bit_idx_r == '0 && !(other_c == '0 && same_c == '0)) begin
            if (other_c != '0) begin
              if (acc_step > best_r) best_nxt = acc_step;
            end else begin
              if (acc_r > best_r) best_nxt = acc_r;
            end
          end
          mem_rd_en   = 1'b1;
          mem_rd_addr = '0;
          node_nxt    = '0;
          bit_idx_nxt = BW'(VALUE_BITS - 1);
          state_nxt   = ST_INSERT;
        end else begin
          mem_rd_en   = 1'b1;
          bit_idx_nxt = bit_idx_r - 1'b1;
          if (other_c != '0) begin
            mem_rd_addr = other_c;
            node_nxt    = other_c;
            acc_nxt     = acc_step;
          end else begin
            mem_rd_addr = same_c;
            node_nxt    = same_c;
          end
        end
      end
      ST_INSERT: begin
        if (same_c != '0) begin
          if (bit_idx_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = same_c;
            node_nxt    = same_c;
            bit_idx_nxt = bit_idx_r - 1'b1;
          end
        end else begin
          // Missing child: hook the next free node into the parent and build
          // the rest of the path without further reads.
          mem_wr_en   = 1'b1;
          mem_wr_addr = node_r;
          mem_wr_data = cur_bit ? {node_count_r[AW-1:0], child0} :
                                  {child1, node_count_r[AW-1:0]};
          seeding_nxt = 1'b0;
          state_nxt   = ST_CHAIN;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_RESTART;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESTART;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seeding_r    <= seeding_nxt;
    value_r      <= value_nxt;
    node_count_r <= node_count_nxt;
    prefix_r     <= prefix_nxt;
    best_r       <= best_nxt;
    acc_r        <= acc_nxt;
    item_count_r <= item_count_nxt;
    bit_idx_r    <= bit_idx_nxt;
    node_r       <= node_nxt;
    full_r       <= full_nxt;
  end

endmodule

// ===== design/max_xor_subarray_trie_unit.sv =====
// Each item walks the trie for its query and then for its insert, one node read a cycle
// through the single read port; an insert that finds a missing child also builds new nodes.
// One item is worked on at a time.
// An item with first set first rewrites the root and seed chain.
// A refused item (capacity) skips both walks and goes straight to its result.
// Reset (rst_n low, synchronous) writes the root and seed chain; in_ready rises once it is written.
`timescale 1ns / 1ps

module max_xor_subarray_trie_unit
  import mxst_pkg::*;
#(
  parameter int unsigned VALUE_BITS     = 31,
  parameter int unsigned MAX_ITEMS      = 1023,
  parameter int unsigned NODE_ADDR_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_value,
  input  logic               in_first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_best_xor,
  output logic               out_full_res
);

  localparam int unsigned AW = NODE_ADDR_BITS;
  localparam int unsigned DW = 2 * AW;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [DW-1:0]      mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [DW-1:0]      mem_rd_data;
  logic               res_valid;
  logic               res_ready;
  logic [FIELD_W-1:0] res_best;
  logic               res_full;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_best_r;
  logic               out_full_r;

  mxst_ctrl #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_ITEMS      (MAX_ITEMS),
    .NODE_ADDR_BITS (NODE_ADDR_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .in_first    (in_first),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_best    (res_best),
    .res_full    (res_full)
  );

  mxst_node_ram #(
    .ADDR_BITS (AW),
    .DATA_BITS (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: the next item can be accepted while a result waits here.
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_best_r <= res_best;
      out_full_r <= res_full;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_xor = out_best_r;
  assign out_full_res = out_full_r;

endmodule

// ===== design/mxst_checker.sv =====
// Port-level checker for max_xor_subarray_trie_unit, attached by bind.
// Depends on mxst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mxst_checker
  import mxst_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_best_xor,
  input logic               out_full_res
);

  // A waiting result holds until its transfer.
  `MXST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_best_xor) && $stable(out_full_res))

  // One item at a time: the input closes right after a transfer.
  `MXST_ASSERT(a_in_closes, in_valid && in_ready |=> !in_ready)

  // Reset starts the seed chain, so no input is taken in the cycle after it.
  `MXST_ASSERT_ALWAYS(a_rst_busy, !rst_n |=> !in_ready)

  // Reset empties the output register.
  `MXST_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

endmodule

bind max_xor_subarray_trie_unit mxst_checker u_mxst_checker (.*);

// ===== tb/tb_max_xor_subarray_trie_unit.sv =====
// Self-checking testbench for the maximum XOR subarray trie unit.
// A clocked driver and monitor work against an in-bench prefix-trie predictor.
// Depends on mxst_pkg and max_xor_subarray_trie_unit.
`timescale 1ns / 1ps

module tb_max_xor_subarray_trie_unit
  import mxst_pkg::*;
();

  localparam int unsigned VALUE_BITS     = 31;
  localparam int unsigned MAX_ITEMS      = 1023;
  localparam int unsigned NODE_ADDR_BITS = 15;
  localparam int unsigned NODE_CAP       = 1 << NODE_ADDR_BITS;
  localparam int          TAIL_QUIET     = 150;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          CYCLE_LIMIT    = 800000;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               first;
  } elem_t;

  typedef struct packed {
    logic [FIELD_W-1:0] best;
    logic               full;
  } xor_result_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] in_value     = '0;
  logic               in_first     = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [FIELD_W-1:0] out_best_xor;
  logic               out_full_res;

  max_xor_subarray_trie_unit #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_ITEMS     (MAX_ITEMS),
    .NODE_ADDR_BITS(NODE_ADDR_BITS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .in_first    (in_first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_best_xor(out_best_xor),
    .out_full_res(out_full_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: child-index pairs, index 0 meaning no child.
  logic [NODE_ADDR_BITS-1:0] kid [2][NODE_CAP];
  int unsigned               nodes_used;
  logic [VALUE_BITS-1:0]     xor_prefix;
  logic [VALUE_BITS-1:0]     best_sofar;
  int unsigned               items_in_seq;

  elem_t       elem_q[$];
  xor_result_t best_q[$];
  elem_t       on_port;
  xor_result_t want;
  int          n_total   = 0;
  int          n_sent    = 0;
  int          n_in_acc  = 0;
  int          n_out_acc = 0;
  int          errs      = 0;
  int          tx_gap    = 0;
  int          rx_gap    = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          cyc       = 0;
  logic        quiet;

  assign quiet = (n_sent + TAIL_QUIET >= n_total);

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errs++;
  endtask

  function automatic void trie_add(input logic [VALUE_BITS-1:0] key);
    int unsigned node;
    int unsigned nxt;
    logic        b;
    int          i;
    node = 0;
    for (i = VALUE_BITS - 1; i >= 0; i--) begin
      b = key[i];
      nxt = kid[b][node];
      if (nxt == 0) begin
        if (nodes_used >= NODE_CAP) return;
        nxt = nodes_used;
        nodes_used++;
        kid[0][nxt] = '0;
        kid[1][nxt] = '0;
        kid[b][node] = nxt[NODE_ADDR_BITS-1:0];
      end
      node = nxt;
    end
  endfunction

  // Greedy walk toward the opposite bit; a node with no child ends the walk with no update.
  function automatic void fold_best_match(input logic [VALUE_BITS-1:0] key);
    int unsigned           node;
    int unsigned           alt;
    int unsigned           same;
    logic [VALUE_BITS-1:0] r;
    int                    i;
    node = 0;
    r = '0;
    for (i = VALUE_BITS - 1; i >= 0; i--) begin
      alt  = kid[!key[i]][node];
      same = kid[key[i]][node];
      if (alt != 0) begin
        r[i] = 1'b1;
        node = alt;
      end else if (same != 0) begin
        node = same;
      end else begin
        return;
      end
    end
    if (r > best_sofar) best_sofar = r;
  endfunction

  function automatic void seq_restart();
    kid[0][0]    = '0;
    kid[1][0]    = '0;
    nodes_used   = 1;
    xor_prefix   = '0;
    best_sofar   = '0;
    items_in_seq = 0;
    trie_add('0);
  endfunction

  function automatic xor_result_t predict_best_xor(input elem_t e);
    xor_result_t res;
    logic        full;
    if (e.first) seq_restart();
    full = (items_in_seq >= MAX_ITEMS) || (nodes_used > NODE_CAP - VALUE_BITS) ||
           (NODE_CAP < VALUE_BITS);
    if (!full) begin
      xor_prefix = xor_prefix ^ e.value[VALUE_BITS-1:0];
      fold_best_match(xor_prefix);
      trie_add(xor_prefix);
      items_in_seq++;
    end
    res.best = FIELD_W'(best_sofar);
    res.full = full;
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_value();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = FIELD_W'($urandom_range(0, 15));
      1:       v = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
      2:       v = ~(FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
      3:       v = '0;
      4:       v = {FIELD_W{1'b1}};
      default: v = FIELD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic void add_item(input logic [FIELD_W-1:0] v, input logic f);
    elem_t e;
    e.value = v;
    e.first = f;
    elem_q.push_back(e);
  endfunction

  // Driver: payload holds until the transfer, then the next item or an idle burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // stalled, keep offering the same item
    end else begin
      if (in_valid) begin
        best_q.push_back(predict_best_xor(on_port));
        n_in_acc <= n_in_acc + 1;
      end
      if (tx_gap != 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (elem_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        tx_gap   <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else begin
        on_port = elem_q.pop_front();
        in_valid <= 1'b1;
        in_value <= on_port.value;
        in_first <= on_port.first;
        n_sent   <= n_sent + 1;
      end
    end
  end

  // One long receiver hold-off early on, so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in_acc >= 40) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap    <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_out_acc <= n_out_acc + 1;
      if (best_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_out_acc));
      end else begin
        want = best_q.pop_front();
        if (out_best_xor !== want.best)
          report_mismatch($sformatf("result %0d best_xor got %h want %h",
                                    n_out_acc, out_best_xor, want.best));
        if (out_full_res !== want.full)
          report_mismatch($sformatf("result %0d full_res got %b want %b",
                                    n_out_acc, out_full_res, want.full));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("tb_max_xor_subarray_trie_unit failed");
      $finish;
    end
  end

  initial begin
    int len;
    seq_restart();

    // Directed: the first value runs on the reset-time trie without a restart.
    add_item('0, 1'b0);
    add_item({FIELD_W{1'b1}}, 1'b0);
    add_item(31'h5555_5555, 1'b0);
    add_item(31'h2AAA_AAAA, 1'b0);
    add_item(31'h0000_0001, 1'b0);
    add_item(31'h4000_0000, 1'b0);
    // Restart carrying the all-ones value, then a restart right after a restart.
    add_item({FIELD_W{1'b1}}, 1'b1);
    add_item('0, 1'b1);
    // Same value twice brings the prefix back to zero, an already stored path.
    add_item({FIELD_W{1'b1}}, 1'b0);
    add_item({FIELD_W{1'b1}}, 1'b0);
    add_item(31'd5, 1'b1);
    add_item(31'd3, 1'b0);
    add_item(31'd6, 1'b0);
    add_item(31'h7FFF_0000, 1'b0);
    add_item(31'h0000_FFFF, 1'b0);
    add_item(31'h4000_0001, 1'b0);

    // Random short sequences with an occasional restart in the middle.
    while (elem_q.size() < 70) begin
      add_item(pick_value(), 1'b1);
      len = $urandom_range(0, 24);
      repeat (len) add_item(pick_value(), $urandom_range(0, 19) == 0);
    end
    // One long sequence that runs past the item capacity, so the last values are refused.
    add_item(pick_value(), 1'b1);
    repeat (MAX_ITEMS + 6) add_item(pick_value(), 1'b0);
    // A restart after capacity was exceeded must bring the block back.
    add_item(pick_value(), 1'b1);
    repeat (5) add_item(pick_value(), 1'b0);
    n_total = elem_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (!(n_in_acc == n_total && n_out_acc >= n_total)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (best_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", best_q.size()));
    if (errs == 0)
      $display("tb_max_xor_subarray_trie_unit passed");
    else
      $display("tb_max_xor_subarray_trie_unit failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mxst_pkg.sv
design/mxst_node_ram.sv
design/mxst_ctrl.sv
design/max_xor_subarray_trie_unit.sv
design/mxst_checker.sv
tb/tb_max_xor_subarray_trie_unit.sv
